/* design/iee_pkg.sv */
// shared types, character codes and constants of the infix expression evaluator
`timescale 1ns / 1ps
package iee_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  localparam int DIV_W       = VALUE_WIDTH + FRAC_BITS;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  localparam val_t VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // largest accumulator that still takes one more digit without overflow
  localparam val_t DIG_LIM [10] = '{
    val_t'((VMAX - (0 << FRAC_BITS)) / 10), val_t'((VMAX - (1 << FRAC_BITS)) / 10),
    val_t'((VMAX - (2 << FRAC_BITS)) / 10), val_t'((VMAX - (3 << FRAC_BITS)) / 10),
    val_t'((VMAX - (4 << FRAC_BITS)) / 10), val_t'((VMAX - (5 << FRAC_BITS)) / 10),
    val_t'((VMAX - (6 << FRAC_BITS)) / 10), val_t'((VMAX - (7 << FRAC_BITS)) / 10),
    val_t'((VMAX - (8 << FRAC_BITS)) / 10), val_t'((VMAX - (9 << FRAC_BITS)) / 10)
  };

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_ILLEGAL = 3'd1,
    STS_UNBAL   = 3'd2,
    STS_SAT     = 3'd3,
    STS_OVF     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_NUM, ST_AFTER, ST_TEST, ST_TEST_RD, ST_POP_B, ST_POP_A,
    ST_ALU_GO, ST_ALU_WAIT, ST_LOOP_EXIT, ST_END_RD, ST_END_VAL, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MODE_CLOSE, MODE_OPER, MODE_END
  } mode_t;

  typedef enum logic [2:0] {
    AS_IDLE, AS_MUL, AS_DIV, AS_FIN, AS_DONE
  } alu_st_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic ok;
  } alu_rsp_t;

  function automatic logic [1:0] prec(input op_t op);
    logic [1:0] p;
    case (op)
      OP_MUL, OP_DIV: p = 2'd2;
      OP_OPEN:        p = 2'd0;
      default:        p = 2'd1;
    endcase
    return p;
  endfunction

endpackage

/* design/iee_stack.sv */
// single-port-write, registered-read stack storage
`timescale 1ns / 1ps
module iee_stack #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/iee_alu.sv */
// shared fixed-point unit with overflow flag: add, subtract, multiply, bit-serial divide
`timescale 1ns / 1ps
module iee_alu import iee_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  input  val_t     a,
  input  val_t     b,
  output alu_rsp_t rsp,
  output val_t     res
);

  localparam int CNT_W = $clog2(DIV_W);

  alu_st_t                st_r, st_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH-1:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [PROD_W-1:0]      mag_r, mag_nxt;
  logic [VALUE_WIDTH:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ok_r, ok_nxt;
  val_t                   res_r, res_nxt;

  logic [VALUE_WIDTH-1:0] ua, ub;
  logic [VALUE_WIDTH:0]   sum, shl;
  logic [PROD_W-1:0]      prod, lim;
  logic                   qb;

  assign ua = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
  assign ub = b[VALUE_WIDTH-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= AS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    neg_r <= neg_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    ok_r  <= ok_nxt;
    res_r <= res_nxt;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      AS_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_MUL:  st_nxt = AS_MUL;
            OP_DIV:  st_nxt = (ub == '0) ? AS_DONE : AS_DIV;
            default: st_nxt = AS_DONE;
          endcase
        end
      end
      AS_MUL:  st_nxt = AS_FIN;
      AS_DIV:  st_nxt = (cnt_r == CNT_W'(DIV_W - 1)) ? AS_FIN : AS_DIV;
      AS_FIN:  st_nxt = AS_DONE;
      AS_DONE: st_nxt = AS_IDLE;
      default: st_nxt = AS_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    neg_nxt = neg_r;
    ma_nxt  = ma_r;
    mb_nxt  = mb_r;
    mag_nxt = mag_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    ok_nxt  = ok_r;
    res_nxt = res_r;
    sum     = '0;
    prod    = ma_r * mb_r;
    shl     = {rem_r[VALUE_WIDTH-1:0], mag_r[PROD_W-1]};
    qb      = shl >= {1'b0, mb_r};
    lim     = PROD_W'(VMAX) + PROD_W'(neg_r);
    case (st_r)
      AS_IDLE: begin
        if (req.start) begin
          neg_nxt = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
          ma_nxt  = ua;
          mb_nxt  = ub;
          ok_nxt  = 1'b1;
          res_nxt = '0;
          case (req.op)
            OP_ADD, OP_SUB: begin
              if (req.op == OP_SUB) begin
                sum = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
              end else begin
                sum = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
              end
              ok_nxt  = !(req.op == OP_SUB && b == VMIN) && (sum[VALUE_WIDTH] == sum[VALUE_WIDTH-1]);
              res_nxt = ok_nxt ? val_t'(sum[VALUE_WIDTH-1:0]) : '0;
            end
            OP_DIV: begin
              // dividend left-aligned so quotient bits fill in from the right
              ok_nxt  = ub != '0;
              mag_nxt = {ua, {(PROD_W-VALUE_WIDTH){1'b0}}};
              rem_nxt = '0;
              cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      AS_MUL: begin
        mag_nxt = prod >> FRAC_BITS;
      end
      AS_DIV: begin
        rem_nxt = qb ? (shl - {1'b0, mb_r}) : shl;
        mag_nxt = {mag_r[PROD_W-2:0], qb};
        cnt_nxt = cnt_r + 1'b1;
      end
      AS_FIN: begin
        ok_nxt  = mag_r <= lim;
        res_nxt = !ok_nxt ? '0 :
                  neg_r ? val_t'(~mag_r[VALUE_WIDTH-1:0] + 1'b1) : val_t'(mag_r[VALUE_WIDTH-1:0]);
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = st_r == AS_DONE;
    rsp.ok   = ok_r;
    res      = res_r;
  end

endmodule

/* design/infix_expression_evaluator.sv */
// top level: character sequencer, operand and operator stacks, shared arithmetic unit
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | in_tdata[7:0] ch, in_tlast end_of_line
//  out_    | out | out_tvalid / out_tready| out_tdata[31:0] value, [34:32] status
//
// each operator application is done in the shared unit, where for / the bit-serial divider
// produces one quotient bit per cycle; a terminator unwinds the operator stack before
// the result is emitted
// in_tready is high only while the sequencer is idle; a waiting result in the
// output register does not stop the next item from being taken
// rst_n is synchronous, active low; the stack memories are not cleared
`timescale 1ns / 1ps
module infix_expression_evaluator import iee_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [34:32] status, rest zero
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  // sequencer and line state
  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          eol_r, eol_nxt;
  logic [CW-1:0] opnd_top_r, opnd_top_nxt;
  logic [CW-1:0] opr_top_r, opr_top_nxt;
  logic [CW-1:0] paren_r, paren_nxt;
  logic          in_num_r, in_num_nxt;
  logic          prev_open_r, prev_open_nxt;
  status_t       status_r, status_nxt;
  op_t           new_op_r, new_op_nxt;
  op_t           cur_op_r, cur_op_nxt;
  val_t          b_r, b_nxt;
  logic          b_rd_r, b_rd_nxt;
  logic          a_rd_r, a_rd_nxt;
  logic          end_rd_r, end_rd_nxt;
  val_t          val_r, val_nxt;
  logic          out_valid_r, out_valid_nxt;
  val_t          out_value_r, out_value_nxt;
  status_t       out_status_r, out_status_nxt;

  // stack ports
  logic          opnd_we, opr_we;
  logic [AW-1:0] opnd_waddr, opnd_raddr, opr_waddr, opr_raddr;
  val_t          opnd_wdata, opnd_rdata;
  logic [2:0]    opr_wdata, opr_rdata;

  // shared unit
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  val_t     alu_a, alu_res;

  // decode helpers
  logic [3:0] dig;
  logic       is_digit, term;
  val_t       add_v, old_v;
  op_t        top_op;

  assign dig      = ch_r[3:0];
  assign is_digit = ch_r inside {[CH_ZERO:CH_NINE]};
  assign term     = eol_r || (ch_r == CH_HASH);
  assign add_v    = val_t'({dig, {FRAC_BITS{1'b0}}});
  assign old_v    = opnd_rdata;
  assign top_op   = op_t'(opr_rdata);
  assign alu_a    = a_rd_r ? opnd_rdata : '0;

  iee_stack #(.DEPTH(STACK_DEPTH), .WIDTH(VALUE_WIDTH)) u_opnd (
    .clk     (clk),
    .wr_en   (opnd_we),
    .wr_addr (opnd_waddr),
    .wr_data (opnd_wdata),
    .rd_addr (opnd_raddr),
    .rd_data (opnd_rdata)
  );

  iee_stack #(.DEPTH(STACK_DEPTH), .WIDTH(3)) u_opr (
    .clk     (clk),
    .wr_en   (opr_we),
    .wr_addr (opr_waddr),
    .wr_data (opr_wdata),
    .rd_addr (opr_raddr),
    .rd_data (opr_rdata)
  );

  iee_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (alu_a),
    .b     (b_r),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      opnd_top_r  <= '0;
      opr_top_r   <= '0;
      paren_r     <= '0;
      in_num_r    <= 1'b0;
      prev_open_r <= 1'b0;
      status_r    <= STS_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      opnd_top_r  <= opnd_top_nxt;
      opr_top_r   <= opr_top_nxt;
      paren_r     <= paren_nxt;
      in_num_r    <= in_num_nxt;
      prev_open_r <= prev_open_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    ch_r         <= ch_nxt;
    eol_r        <= eol_nxt;
    new_op_r     <= new_op_nxt;
    cur_op_r     <= cur_op_nxt;
    b_r          <= b_nxt;
    b_rd_r       <= b_rd_nxt;
    a_rd_r       <= a_rd_nxt;
    end_rd_r     <= end_rd_nxt;
    val_r        <= val_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_r != STS_OK || ch_r == CH_HASH) begin
          state_nxt = ST_AFTER;
        end else if (is_digit) begin
          state_nxt = in_num_r ? ST_NUM : ST_AFTER;
        end else if (ch_r == CH_CLOSE) begin
          state_nxt = (prev_open_r || paren_r == '0) ? ST_AFTER : ST_TEST;
        end else if (ch_r == CH_PLUS || ch_r == CH_MINUS || ch_r == CH_STAR ||
                     ch_r == CH_SLASH) begin
          state_nxt = ST_TEST;
        end else begin
          state_nxt = ST_AFTER;
        end
      end
      ST_NUM:   state_nxt = ST_AFTER;
      ST_AFTER: state_nxt = term ? ST_TEST : ST_IDLE;
      ST_TEST: begin
        state_nxt = (status_r != STS_OK || opr_top_r == '0) ? ST_LOOP_EXIT : ST_TEST_RD;
      end
      ST_TEST_RD: begin
        if (mode_r == MODE_CLOSE && top_op == OP_OPEN) begin
          state_nxt = ST_AFTER;
        end else if (mode_r == MODE_OPER &&
                     (top_op == OP_OPEN || prec(top_op) < prec(new_op_r))) begin
          state_nxt = ST_LOOP_EXIT;
        end else if (top_op == OP_OPEN || opr_rdata > OP_DIV) begin
          state_nxt = ST_TEST;
        end else begin
          state_nxt = ST_POP_B;
        end
      end
      ST_POP_B:     state_nxt = ST_POP_A;
      ST_POP_A:     state_nxt = ST_ALU_GO;
      ST_ALU_GO:    state_nxt = ST_ALU_WAIT;
      ST_ALU_WAIT:  state_nxt = alu_rsp.done ? ST_TEST : ST_ALU_WAIT;
      ST_LOOP_EXIT: state_nxt = (mode_r == MODE_END) ? ST_END_RD : ST_AFTER;
      ST_END_RD:    state_nxt = ST_END_VAL;
      ST_END_VAL:   state_nxt = ST_EMIT;
      ST_EMIT:      state_nxt = (!out_valid_r || out_tready) ? ST_IDLE : ST_EMIT;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // register updates and stack accesses
  always_comb begin
    mode_nxt       = mode_r;
    ch_nxt         = ch_r;
    eol_nxt        = eol_r;
    opnd_top_nxt   = opnd_top_r;
    opr_top_nxt    = opr_top_r;
    paren_nxt      = paren_r;
    in_num_nxt     = in_num_r;
    prev_open_nxt  = prev_open_r;
    status_nxt     = status_r;
    new_op_nxt     = new_op_r;
    cur_op_nxt     = cur_op_r;
    b_nxt          = b_r;
    b_rd_nxt       = b_rd_r;
    a_rd_nxt       = a_rd_r;
    end_rd_nxt     = end_rd_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    opnd_we        = 1'b0;
    opnd_waddr     = '0;
    opnd_wdata     = '0;
    opnd_raddr     = AW'(opnd_top_r - 1'b1);
    opr_we         = 1'b0;
    opr_waddr      = '0;
    opr_wdata      = '0;
    opr_raddr      = AW'(opr_top_r - 1'b1);
    alu_req.start  = 1'b0;
    alu_req.op     = cur_op_r;
    in_tready      = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ch_nxt    = in_tdata;
        eol_nxt   = in_tlast;
      end
      ST_DECODE: begin
        if (status_r == STS_OK && ch_r != CH_HASH) begin
          if (is_digit) begin
            prev_open_nxt = 1'b0;
            // first digit of a literal is pushed directly, later ones via read-modify-write
            if (!in_num_r) begin
              if (opnd_top_r == DEPTH_C) begin
                status_nxt = STS_OVF;
              end else begin
                opnd_we      = 1'b1;
                opnd_waddr   = AW'(opnd_top_r);
                opnd_wdata   = add_v;
                opnd_top_nxt = opnd_top_r + 1'b1;
                in_num_nxt   = 1'b1;
              end
            end
          end else begin
            in_num_nxt = 1'b0;
            case (ch_r)
              CH_OPEN: begin
                if (opr_top_r == DEPTH_C) begin
                  status_nxt = STS_OVF;
                end else begin
                  opr_we        = 1'b1;
                  opr_waddr     = AW'(opr_top_r);
                  opr_wdata     = OP_OPEN;
                  opr_top_nxt   = opr_top_r + 1'b1;
                  paren_nxt     = paren_r + 1'b1;
                  prev_open_nxt = 1'b1;
                end
              end
              CH_CLOSE: begin
                mode_nxt = MODE_CLOSE;
                if (prev_open_r) begin
                  status_nxt = STS_ILLEGAL;
                end else if (paren_r == '0) begin
                  status_nxt = STS_UNBAL;
                end
              end
              CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                prev_open_nxt = 1'b0;
                mode_nxt      = MODE_OPER;
                case (ch_r)
                  CH_PLUS:  new_op_nxt = OP_ADD;
                  CH_MINUS: new_op_nxt = OP_SUB;
                  CH_STAR:  new_op_nxt = OP_MUL;
                  default:  new_op_nxt = OP_DIV;
                endcase
              end
              default: begin
                prev_open_nxt = 1'b0;
                status_nxt    = STS_ILLEGAL;
              end
            endcase
          end
        end
      end
      ST_NUM: begin
        // accumulator = accumulator * 10 + digit; on overflow the status is set to saturated
        if (old_v > DIG_LIM[dig]) begin
          status_nxt = STS_SAT;
        end else begin
          opnd_we    = 1'b1;
          opnd_waddr = AW'(opnd_top_r - 1'b1);
          opnd_wdata = (old_v <<< 3) + (old_v <<< 1) + add_v;
        end
      end
      ST_AFTER: begin
        if (term) begin
          mode_nxt = MODE_END;
          if (status_r == STS_OK && paren_r != '0) begin
            status_nxt = STS_UNBAL;
          end
        end
      end
      ST_TEST_RD: begin
        if (mode_r == MODE_CLOSE && top_op == OP_OPEN) begin
          opr_top_nxt = opr_top_r - 1'b1;
          paren_nxt   = paren_r - 1'b1;
        end else if (!(mode_r == MODE_OPER &&
                       (top_op == OP_OPEN || prec(top_op) < prec(new_op_r)))) begin
          opr_top_nxt = opr_top_r - 1'b1;
          cur_op_nxt  = top_op;
        end
      end
      ST_POP_B: begin
        b_rd_nxt = opnd_top_r != '0;
        if (opnd_top_r != '0) begin
          opnd_top_nxt = opnd_top_r - 1'b1;
        end
      end
      ST_POP_A: begin
        b_nxt    = b_rd_r ? opnd_rdata : '0;
        a_rd_nxt = opnd_top_r != '0;
        if (opnd_top_r != '0) begin
          opnd_top_nxt = opnd_top_r - 1'b1;
        end
      end
      ST_ALU_GO: begin
        alu_req.start = 1'b1;
      end
      ST_ALU_WAIT: begin
        if (alu_rsp.done) begin
          if (!alu_rsp.ok) begin
            status_nxt = (status_r == STS_OK) ? STS_SAT : status_r;
          end
          if (opnd_top_r == DEPTH_C) begin
            status_nxt = (status_nxt == STS_OK) ? STS_OVF : status_nxt;
          end else begin
            opnd_we      = 1'b1;
            opnd_waddr   = AW'(opnd_top_r);
            opnd_wdata   = alu_rsp.ok ? alu_res : '0;
            opnd_top_nxt = opnd_top_r + 1'b1;
          end
        end
      end
      ST_LOOP_EXIT: begin
        if (status_r == STS_OK) begin
          if (mode_r == MODE_CLOSE) begin
            if (opr_top_r != '0) begin
              opr_top_nxt = opr_top_r - 1'b1;
            end
            paren_nxt = paren_r - 1'b1;
          end else if (mode_r == MODE_OPER) begin
            if (opr_top_r == DEPTH_C) begin
              status_nxt = STS_OVF;
            end else begin
              opr_we      = 1'b1;
              opr_waddr   = AW'(opr_top_r);
              opr_wdata   = new_op_r;
              opr_top_nxt = opr_top_r + 1'b1;
            end
          end
        end
      end
      ST_END_RD: begin
        end_rd_nxt = status_r == STS_OK && opnd_top_r != '0;
      end
      ST_END_VAL: begin
        val_nxt = end_rd_r ? opnd_rdata : '0;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = (status_r == STS_OK) ? val_r : '0;
          out_status_nxt = status_r;
          // line finished: back to the reset picture
          opnd_top_nxt   = '0;
          opr_top_nxt    = '0;
          paren_nxt      = '0;
          in_num_nxt     = 1'b0;
          prev_open_nxt  = 1'b0;
          status_nxt     = STS_OK;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_status_r, out_value_r};

  // a flagged result always carries a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] != STS_OK |-> out_tdata[31:0] == '0)
    else $error("nonzero value with error status");

  // stack pointers never pass the storage depth
  assert property (@(posedge clk) disable iff (!rst_n)
    opnd_top_r <= DEPTH_C && opr_top_r <= DEPTH_C)
    else $error("stack pointer beyond depth");

  // the shared unit only finishes while the sequencer waits on it
  assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == ST_ALU_WAIT)
    else $error("arithmetic result outside wait state");

  // a started operation is followed by the wait state
  assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |=> state_r == ST_ALU_WAIT)
    else $error("start without wait");

endmodule
